// ----- rtl/modbus_rtu_slave_frame_engine_defines.svh -----
// Assertion macros used by the top-level RTL file of the Modbus RTU slave frame engine.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- rtl/mbrtu_pkg.sv -----
// Shared constants, types and functions of the Modbus RTU slave frame engine.
package mbrtu_pkg;

  localparam int REG_COUNT = 32;
  localparam int MAX_READ  = 29;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int WORD_CW   = $clog2(MAX_READ + 1);

  localparam logic [1:0] OP_RX  = 2'd0;
  localparam logic [1:0] OP_LWR = 2'd1;
  localparam logic [1:0] OP_LRD = 2'd2;

  localparam logic [1:0] CFG_SLAVE_ADDR   = 2'd0;
  localparam logic [1:0] CFG_REGS_IN_USE  = 2'd1;

  localparam logic [7:0]  FC_READ  = 8'h03;
  localparam logic [7:0]  FC_WRITE = 8'h06;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] REG1_RESET = 16'd5678;
  localparam logic [15:0] REG2_RESET = 16'd90;

  typedef logic [2:0] tx_sel_t;
  localparam tx_sel_t SEL_ADDR  = 3'd0;
  localparam tx_sel_t SEL_FC    = 3'd1;
  localparam tx_sel_t SEL_BCNT  = 3'd2;
  localparam tx_sel_t SEL_HI    = 3'd3;
  localparam tx_sel_t SEL_LO    = 3'd4;
  localparam tx_sel_t SEL_CRCLO = 3'd5;
  localparam tx_sel_t SEL_CRCHI = 3'd6;
  localparam tx_sel_t SEL_REQ   = 3'd7;

  typedef struct packed {
    logic               capture;
    logic               store_byte;
    logic               wr_local;
    logic               rd_local;
    logic               wr_req06;
    logic               rd_word;
    logic               emit;
    logic               emit_local;
    tx_sel_t            sel;
    logic               last;
    logic               crc_init;
    logic               crc_acc;
    logic [2:0]         cnt;
    logic [WORD_CW-1:0] wi;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_last;
    logic       req_ok;
    logic       fc03_ok;
    logic       fc06;
    logic       v_zero;
    logic       word_last;
    logic       out_free;
  } dp_stat_t;

  // One byte of the reflected CRC-16 used by Modbus RTU.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Value a holding register has after reset, before it is first written.
  function automatic logic [15:0] reg_reset_value(input logic [REG_AW-1:0] idx);
    logic [15:0] v;
    v = 16'h0000;
    if (idx == REG_AW'(1)) v = REG1_RESET;
    if (idx == REG_AW'(2)) v = REG2_RESET;
    return v;
  endfunction

endpackage

// ----- rtl/modbus_rtu_slave_frame_engine.sv -----
// A serial or local write item is captured and then acted on in the decode state; a local read
// item is read from register memory in decode, then loaded into the output register. The eighth
// request byte is stored and checked before the first reply byte. Reply bytes (header, CRC, echo)
// leave one per cycle while the output is not stalled; a read word needs a memory read first.
// Reset (rst, synchronous) clears control state and the register valid bits; unwritten
// registers read as their reset values (register 1 = 5678, register 2 = 90), no clearing pass.
module modbus_rtu_slave_frame_engine (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port: index 0 slave_address, index 1 registers_in_use.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // rx_byte[7:0], local_address[23:8], local_value[39:24]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tx_byte[7:0], read_value[23:8]
  output logic        m_tuser,   // kind[0]
  output logic        m_tlast
);
  import mbrtu_pkg::*;
  `include "modbus_rtu_slave_frame_engine_defines.svh"

  // The controller sequences one input item at a time. It accepts an item only in its idle
  // state, then issues commands to the datapath, which owns all storage: the configuration
  // registers, the eight byte request collector with its running CRC, the holding register
  // memory (one write and one registered read port) and the output register.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mbrtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The output register decouples the two sides: a finished item waits there while the
  // controller goes back to idle and takes the next input item.
  mbrtu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // A result item is only loaded when the output register is free or being emptied.
  `ASSERT_CLK(a_emit_slot, cmd.emit |-> stat.out_free, "result loaded over a pending item")
  // Intake and reply generation never overlap.
  `ASSERT_CLK(a_no_accept_emit, (s_tvalid && s_tready) |-> !cmd.emit, "accept during emit")
  // An accepted item is decoded in the cycle after it is taken, so no second item is taken then.
  `ASSERT_NEXT(a_no_back_accept, s_tvalid && s_tready, !s_tready, "second item taken early")
  // Local read data never carries a frame end or a transmit byte.
  `ASSERT_CLK(a_local_fmt, (m_tvalid && m_tuser) |-> (!m_tlast && (m_tdata[7:0] == 8'h00)),
              "malformed local read item")

endmodule

// ----- rtl/mbrtu_dp.sv -----
// Datapath: configuration, request collector, CRC, holding register memory, output register.
module mbrtu_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [39:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  mbrtu_pkg::dp_cmd_t cmd,
  output mbrtu_pkg::dp_stat_t stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);
  import mbrtu_pkg::*;

  logic [7:0]  slave_address;
  logic [5:0]  registers_in_use;
  logic [15:0] vcount;

  logic [1:0]  op;
  logic [7:0]  rx;
  logic [15:0] la;
  logic [15:0] lv;

  logic [7:0]  req [8];
  logic [2:0]  byte_index;
  logic [15:0] rx_crc;
  logic [15:0] tx_crc;

  logic [15:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] reg_vld;
  logic [15:0] rd_q;
  logic [15:0] rd_rst;
  logic        rd_hit;
  logic [15:0] word;

  logic [15:0] req_a;
  logic [15:0] req_v;
  logic [15:0] word_addr;
  logic        rd_en;
  logic [REG_AW-1:0] rd_addr;
  logic        wr_en;
  logic [REG_AW-1:0] wr_addr;
  logic [15:0] wr_data;
  logic [7:0]  tx_byte;
  logic        la_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= 8'd1;
      registers_in_use <= 6'd32;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SLAVE_ADDR)  slave_address    <= cfg_data;
      if (cfg_index == CFG_REGS_IN_USE) registers_in_use <= cfg_data[5:0];
    end
  end

  assign vcount = ({10'h000, registers_in_use} > 16'(REG_COUNT)) ?
                  16'(REG_COUNT) : {10'h000, registers_in_use};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= s_tuser;
      rx <= s_tdata[7:0];
      la <= s_tdata[23:8];
      lv <= s_tdata[39:24];
    end
  end

  // Running CRC over request bytes 0..5, restarted with byte 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 3'd0;
    end else if (cmd.store_byte) begin
      byte_index <= byte_index + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      req[byte_index] <= rx;
      if (byte_index < 3'd6) begin
        rx_crc <= crc16_update((byte_index == 3'd0) ? CRC_INIT : rx_crc, rx);
      end
    end
  end

  assign req_a     = {req[2], req[3]};
  assign req_v     = {req[4], req[5]};
  assign word_addr = req_a + 16'(cmd.wi);
  assign la_ok     = la < vcount;

  assign wr_en   = (cmd.wr_local && la_ok) || (cmd.wr_req06 && (req_a < vcount));
  assign wr_addr = cmd.wr_local ? la[REG_AW-1:0] : req_a[REG_AW-1:0];
  assign wr_data = cmd.wr_local ? lv : req_v;
  assign rd_en   = cmd.rd_local || cmd.rd_word;
  assign rd_addr = cmd.rd_local ? la[REG_AW-1:0] : word_addr[REG_AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_hit <= reg_vld[rd_addr];
      rd_rst <= reg_reset_value(rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_vld <= '0;
    end else if (wr_en) begin
      reg_vld[wr_addr] <= 1'b1;
    end
  end

  assign word = rd_hit ? rd_q : rd_rst;

  always_comb begin
    case (cmd.sel)
      SEL_ADDR:  tx_byte = slave_address;
      SEL_FC:    tx_byte = FC_READ;
      SEL_BCNT:  tx_byte = {req_v[6:0], 1'b0};
      SEL_HI:    tx_byte = word[15:8];
      SEL_LO:    tx_byte = word[7:0];
      SEL_CRCLO: tx_byte = tx_crc[7:0];
      SEL_CRCHI: tx_byte = tx_crc[15:8];
      default:   tx_byte = req[cmd.cnt];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.crc_init) begin
      tx_crc <= CRC_INIT;
    end else if (cmd.crc_acc) begin
      tx_crc <= crc16_update(tx_crc, tx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_local) begin
        m_tdata <= {(la_ok ? word : 16'h0000), 8'h00};
        m_tuser <= 1'b1;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {16'h0000, tx_byte};
        m_tuser <= 1'b0;
        m_tlast <= cmd.last;
      end
    end
  end

  assign stat.op        = op;
  assign stat.idx_last  = (byte_index == 3'd7);
  assign stat.req_ok    = (req[0] == slave_address) && ({req[7], req[6]} == rx_crc);
  assign stat.fc03_ok   = (req[1] == FC_READ) &&
                          (({1'b0, req_a} + {1'b0, req_v}) <= {1'b0, vcount}) &&
                          (req_v <= 16'(MAX_READ));
  assign stat.fc06      = (req[1] == FC_WRITE);
  assign stat.v_zero    = (req_v == 16'h0000);
  assign stat.word_last = ((16'(cmd.wi) + 16'd1) == req_v);
  assign stat.out_free  = !m_tvalid || m_tready;

endmodule

// ----- rtl/mbrtu_ctrl.sv -----
// Controller: state machine that sequences request intake, checks and reply bytes.
module mbrtu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mbrtu_pkg::dp_stat_t stat,
  output mbrtu_pkg::dp_cmd_t  cmd
);
  import mbrtu_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_LRD    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_HDR    = 4'd4;
  localparam logic [3:0] S_RDISS  = 4'd5;
  localparam logic [3:0] S_RDHI   = 4'd6;
  localparam logic [3:0] S_RDLO   = 4'd7;
  localparam logic [3:0] S_CRCLO  = 4'd8;
  localparam logic [3:0] S_CRCHI  = 4'd9;
  localparam logic [3:0] S_ECHO   = 4'd10;

  logic [3:0]         state, state_next;
  logic [2:0]         cnt, cnt_next;
  logic [WORD_CW-1:0] wi, wi_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 3'd0;
      wi    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      wi    <= wi_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    wi_next    = wi;
    cmd        = '0;
    cmd.cnt    = cnt;
    cmd.wi     = wi;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_RX: begin
            cmd.store_byte = 1'b1;
            state_next     = stat.idx_last ? S_CHECK : S_IDLE;
          end
          OP_LWR: begin
            cmd.wr_local = 1'b1;
            state_next   = S_IDLE;
          end
          OP_LRD: begin
            cmd.rd_local = 1'b1;
            state_next   = S_LRD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LRD: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_local = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_CHECK: begin
        cnt_next = 3'd0;
        if (stat.req_ok && stat.fc03_ok) begin
          cmd.crc_init = 1'b1;
          state_next   = S_HDR;
        end else if (stat.req_ok && stat.fc06) begin
          cmd.wr_req06 = 1'b1;
          state_next   = S_ECHO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HDR: begin
        cmd.sel = (cnt == 3'd0) ? SEL_ADDR : ((cnt == 3'd1) ? SEL_FC : SEL_BCNT);
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.crc_acc = 1'b1;
          if (cnt == 3'd2) begin
            wi_next    = '0;
            state_next = stat.v_zero ? S_CRCLO : S_RDISS;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      S_RDISS: begin
        cmd.rd_word = 1'b1;
        state_next  = S_RDHI;
      end
      S_RDHI: begin
        cmd.sel = SEL_HI;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.crc_acc = 1'b1;
          state_next  = S_RDLO;
        end
      end
      S_RDLO: begin
        cmd.sel = SEL_LO;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.crc_acc = 1'b1;
          if (stat.word_last) begin
            state_next = S_CRCLO;
          end else begin
            wi_next    = wi + WORD_CW'(1);
            state_next = S_RDISS;
          end
        end
      end
      S_CRCLO: begin
        cmd.sel = SEL_CRCLO;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_CRCHI;
        end
      end
      S_CRCHI: begin
        cmd.sel  = SEL_CRCHI;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ECHO: begin
        cmd.sel  = SEL_REQ;
        cmd.last = (cnt == 3'd7);
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (cnt == 3'd7) begin
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
